// ----- src/sts_pkg.sv -----
package sts_pkg;

	localparam int DEFAULT_CAPACITY = 1024;
	localparam int KEY_W = 64;
	localparam int WORD_W = 64;
	localparam int SLOT_W = 10;
	localparam int STATUS_W = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic op;
		logic [KEY_W-1:0] stamp;
		logic [WORD_W-1:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0] found_word;
		logic [SLOT_W-1:0] slot;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [WORD_W-1:0] word;
	} entry_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

endpackage

// ----- src/sts_cmp.sv -----
module sts_cmp (
	input logic [sts_pkg::KEY_W-1:0] a,
	input logic [sts_pkg::KEY_W-1:0] b,
	output sts_pkg::cmp_t res
);

	assign res.lt = (a < b);
	assign res.eq = (a == b);

endmodule

// ----- src/sts_core.sv -----
module sts_core #(
	parameter int CAPACITY = sts_pkg::DEFAULT_CAPACITY
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input sts_pkg::in_item_t req,
	output logic ready,
	output logic [sts_pkg::KEY_W-1:0] cmp_a,
	output logic [sts_pkg::KEY_W-1:0] cmp_b,
	input sts_pkg::cmp_t cmp,
	output logic rsp_valid,
	output sts_pkg::out_item_t rsp,
	input logic rsp_ready
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_PROBE,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t state_q;
	logic op_q;
	logic [sts_pkg::KEY_W-1:0] stamp_q;
	logic [sts_pkg::WORD_W-1:0] word_q;
	logic [CW-1:0] lo_q, hi_q, mid_q, count_q;
	logic [CW-1:0] rd_ptr_q, wr_ptr_q;
	logic pend_q;
	logic hit_q;
	logic [sts_pkg::WORD_W-1:0] found_q;
	sts_pkg::out_item_t rsp_q;

	sts_pkg::entry_t mem_q [CAPACITY];
	sts_pkg::entry_t rd_data_q;

	logic mem_re, mem_we;
	logic [AW-1:0] mem_raddr, mem_waddr;
	sts_pkg::entry_t mem_wdata;
	logic [CW-1:0] mid, rd_prev;

	function automatic logic [sts_pkg::SLOT_W-1:0] to_slot(input logic [CW-1:0] p);
		logic [CW+sts_pkg::SLOT_W-1:0] w;
		w = (CW + sts_pkg::SLOT_W)'(p);
		return w[sts_pkg::SLOT_W-1:0];
	endfunction

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_prev = rd_ptr_q - CW'(1);

	assign ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RESP);
	assign rsp = rsp_q;
	assign cmp_a = rd_data_q.key;
	assign cmp_b = stamp_q;

	// The shift runs as a two-deep pipeline: the entry read in one cycle is
	// written one place higher in the next, while the next lower entry is read.
	always_comb begin
		mem_re = 1'b0;
		mem_raddr = '0;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = rd_data_q;
		case (state_q)
			S_SEARCH: begin
				if (lo_q < hi_q) begin
					mem_re = 1'b1;
					mem_raddr = mid[AW-1:0];
				end
			end
			S_SHIFT: begin
				if (pend_q) begin
					mem_we = 1'b1;
					mem_waddr = wr_ptr_q[AW-1:0];
				end
				if (rd_ptr_q > lo_q) begin
					mem_re = 1'b1;
					mem_raddr = rd_prev[AW-1:0];
				end else if (!pend_q) begin
					mem_we = 1'b1;
					mem_waddr = lo_q[AW-1:0];
					mem_wdata.key = stamp_q;
					mem_wdata.word = word_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_raddr];
		end
	end

	// At the end of the search lo equals hi, and hit_q and found_q describe the
	// entry at hi whenever hi was set by a probe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q <= 1'b0;
			hit_q <= 1'b0;
			op_q <= sts_pkg::OP_INSERT;
			stamp_q <= '0;
			word_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			mid_q <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			found_q <= '0;
			rsp_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q <= req.op;
						stamp_q <= req.stamp;
						word_q <= req.data_word;
						lo_q <= '0;
						hi_q <= count_q;
						hit_q <= 1'b0;
						found_q <= '0;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (lo_q < hi_q) begin
						mid_q <= mid;
						state_q <= S_PROBE;
					end else if (op_q == sts_pkg::OP_LOOKUP) begin
						rsp_q.status <= hit_q ? sts_pkg::ST_OK : sts_pkg::ST_MISS;
						rsp_q.found_word <= hit_q ? found_q : '0;
						rsp_q.slot <= hit_q ? to_slot(lo_q) : '0;
						state_q <= S_RESP;
					end else if (hit_q || (count_q >= CW'(CAPACITY))) begin
						rsp_q.status <= hit_q ? sts_pkg::ST_MISS : sts_pkg::ST_FULL;
						rsp_q.found_word <= '0;
						rsp_q.slot <= '0;
						state_q <= S_RESP;
					end else begin
						rd_ptr_q <= count_q;
						pend_q <= 1'b0;
						state_q <= S_SHIFT;
					end
				end
				S_PROBE: begin
					if (cmp.lt) begin
						lo_q <= mid_q + CW'(1);
					end else begin
						hi_q <= mid_q;
						hit_q <= cmp.eq;
						found_q <= rd_data_q.word;
					end
					state_q <= S_SEARCH;
				end
				S_SHIFT: begin
					if (rd_ptr_q > lo_q) begin
						wr_ptr_q <= rd_ptr_q;
						rd_ptr_q <= rd_prev;
						pend_q <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						count_q <= count_q + CW'(1);
						rsp_q.status <= sts_pkg::ST_OK;
						rsp_q.found_word <= '0;
						rsp_q.slot <= to_slot(lo_q);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/sorted_timestamp_table.sv -----
// Channel   Direction   Handshake             Payload
// req       in          req_valid/req_stall   sts_pkg::in_item_t  (op, stamp, data_word)
// rsp       out         rsp_valid/rsp_stall   sts_pkg::out_item_t (status, found_word, slot)
//
// One item is handled at a time; req_stall stays high from acceptance until the result
// moves into the output register. Each binary search probe reads the entry memory, then
// compares the entry with the stamp. An insert moves later entries up one place through
// the single read and single write port of the entry memory. Reset clears the entry count
// and the control registers, not the entry memory, which needs no clearing pass.
// A result waits in the output register while rsp_stall is high; the next item is still
// taken and searched, and its result waits until the register frees.
module sorted_timestamp_table #(
	parameter int CAPACITY = sts_pkg::DEFAULT_CAPACITY
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input sts_pkg::in_item_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output sts_pkg::out_item_t rsp
);

	logic core_ready;
	logic core_rsp_valid;
	logic core_rsp_ready;
	sts_pkg::out_item_t core_rsp;
	logic [sts_pkg::KEY_W-1:0] cmp_a, cmp_b;
	sts_pkg::cmp_t cmp;
	logic rsp_valid_q;
	sts_pkg::out_item_t rsp_q;

	sts_cmp u_cmp (
		.a(cmp_a),
		.b(cmp_b),
		.res(cmp)
	);

	sts_core #(
		.CAPACITY(CAPACITY)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.ready(core_ready),
		.cmp_a(cmp_a),
		.cmp_b(cmp_b),
		.cmp(cmp),
		.rsp_valid(core_rsp_valid),
		.rsp(core_rsp),
		.rsp_ready(core_rsp_ready)
	);

	assign req_stall = !core_ready;
	assign core_rsp_ready = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (core_rsp_valid && core_rsp_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_rsp_valid && core_rsp_ready) begin
			rsp_q <= core_rsp;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("block took an item without turning busy");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(core_rsp_valid && core_rsp_ready) |=> (rsp_valid && !req_stall))
		else $error("handed-over result did not reach the output register");

	a_fail_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status != sts_pkg::ST_OK)) |->
		((rsp.found_word == '0) && (rsp.slot == '0)))
		else $error("failed item carries a nonzero word or slot");

endmodule
